/* src/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the frame deframer
// Parse phases, result kinds, opcodes and the result record passed from the
// parser to the output register.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// Header fields
	localparam logic [3:0] OP_CLOSE   = 4'h8;
	localparam logic [3:0] OP_PONG    = 4'hA;
	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;
	localparam logic [2:0] EXT16_CNT  = 3'd2;
	localparam logic [2:0] EXT64_CNT  = 3'd0;   // eight bytes, 3-bit count wraps
	localparam logic [2:0] KEY_CNT    = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CLOSED  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_CLOSE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       last;
	} res_t;

endpackage

/* src/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser: frame header state machine and payload unmasking
// Consumes one byte per step, updates the frame state and produces at most
// one result for that byte.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output res_t       res
);

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [63:0] bytes_q, bytes_d;
	logic [2:0]  ext_q, ext_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kidx_q, kidx_d;
	logic        pong_q, pong_d;

	logic [6:0]  len7;
	logic [63:0] ext_len;
	logic [2:0]  ext_dec;
	logic [1:0]  key_sel;
	logic [7:0]  key_byte;

	assign len7     = rx_byte[6:0];
	assign ext_len  = {bytes_q[55:0], rx_byte};
	assign ext_dec  = ext_q - 3'd1;
	assign key_sel  = 2'd3 - kidx_q;
	assign key_byte = masked_q ? key_q[{key_sel, 3'b000} +: 8] : 8'h00;

	// Next state
	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		masked_d = masked_q;
		bytes_d  = bytes_q;
		ext_d    = ext_q;
		key_d    = key_q;
		kidx_d   = kidx_q;
		pong_d   = pong_q;
		case (phase_q)
			PH_CLOSED: begin
			end
			PH_LENGTH: begin
				masked_d = rx_byte[7];
				if (len7 == LEN_EXT16) begin
					bytes_d = '0;
					ext_d   = EXT16_CNT;
					phase_d = PH_EXTLEN;
				end else if (len7 == LEN_EXT64) begin
					bytes_d = '0;
					ext_d   = EXT64_CNT;
					phase_d = PH_EXTLEN;
				end else begin
					bytes_d = {57'd0, len7};
					if (rx_byte[7]) begin
						ext_d   = KEY_CNT;
						key_d   = '0;
						phase_d = PH_KEY;
					end else begin
						kidx_d  = '0;
						phase_d = (len7 != 7'd0) ? PH_PAYLOAD : PH_HEADER;
					end
				end
			end
			PH_EXTLEN: begin
				bytes_d = ext_len;
				ext_d   = ext_dec;
				if (ext_dec == 3'd0) begin
					if (masked_q) begin
						ext_d   = KEY_CNT;
						key_d   = '0;
						phase_d = PH_KEY;
					end else begin
						kidx_d  = '0;
						phase_d = (ext_len != 64'd0) ? PH_PAYLOAD : PH_HEADER;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				ext_d = ext_dec;
				if (ext_dec == 3'd0) begin
					kidx_d  = '0;
					phase_d = (bytes_q != 64'd0) ? PH_PAYLOAD : PH_HEADER;
				end
			end
			PH_PAYLOAD: begin
				kidx_d  = kidx_q + 2'd1;
				bytes_d = bytes_q - 64'd1;
				if (bytes_q == 64'd1)
					phase_d = PH_HEADER;
			end
			default: begin
				// first header byte; FIN and RSV are ignored
				opcode_d = rx_byte[3:0];
				if (rx_byte[3:0] == OP_CLOSE) begin
					phase_d = PH_CLOSED;
				end else begin
					pong_d  = (rx_byte[3:0] == OP_PONG);
					phase_d = PH_LENGTH;
				end
			end
		endcase
	end

	// Result for the current byte
	always_comb begin
		res_valid  = 1'b0;
		res.kind   = KIND_EMPTY;
		res.data   = 8'h00;
		res.opcode = opcode_q;
		res.last   = 1'b1;
		case (phase_q)
			PH_CLOSED: begin
			end
			PH_LENGTH: begin
				res_valid = (len7 == 7'd0) && !rx_byte[7] && !pong_q;
			end
			PH_EXTLEN: begin
				res_valid = (ext_q == 3'd1) && !masked_q && (ext_len == 64'd0) && !pong_q;
			end
			PH_KEY: begin
				res_valid = (ext_q == 3'd1) && (bytes_q == 64'd0) && !pong_q;
			end
			PH_PAYLOAD: begin
				res_valid = !pong_q;
				res.kind  = KIND_DATA;
				res.data  = rx_byte ^ key_byte;
				res.last  = (bytes_q == 64'd1);
			end
			default: begin
				res.opcode = rx_byte[3:0];
				res.kind   = KIND_CLOSE;
				res_valid  = (rx_byte[3:0] == OP_CLOSE);
			end
		endcase
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			opcode_q <= '0;
			masked_q <= 1'b0;
			bytes_q  <= '0;
			ext_q    <= '0;
			key_q    <= '0;
			kidx_q   <= '0;
			pong_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			bytes_q  <= bytes_d;
			ext_q    <= ext_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
			pong_q   <= pong_d;
		end
	end

endmodule

/* src/wsd_out_stage.sv */
// ----------------------------------------------------------------------------
// wsd_out_stage: result register with valid/ready handshake
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage import wsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res,
	output logic free,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule

/* src/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side frame parser
// Input register, header/payload parser and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: rx_byte with in_valid/in_ready, one stream byte per request.
//   Output channel: kind, data_byte, frame_opcode, last_in_frame with
//   out_valid/out_ready. Header bytes, masking key bytes and pong frames give
//   no output; payload bytes give one data request each, an empty frame gives
//   one marker and a close header gives one close event.
//   Path: a byte passes the input register, the parser and the result register.
//   Throughput: one byte per cycle while the result register is free, set
//   by the single parser step between the input and result registers.
//   Stall: a held result blocks the parser only while out_ready is low; the
//   input register then holds at most one byte, and in_ready drops once full.
//   Reset: arst_n clears both registers' valid flags and the frame state; the
//   parser waits for a first header byte. After a close frame every byte is
//   accepted and dropped until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [3:0] frame_opcode,
	output logic       last_in_frame
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       free;
	logic       step;
	logic       res_valid;
	res_t       res;
	res_t       out_res;

	assign step     = valid_s1 && free;
	assign in_ready = !valid_s1 || free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res       (res),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind          = out_res.kind;
	assign data_byte     = out_res.data;
	assign frame_opcode  = out_res.opcode;
	assign last_in_frame = out_res.last;

endmodule
